/* hdl/plrf_pkg.sv */
// Shared types and constants for the paged LCD rectangle fill block.
// Holds the port payload structs, the front-to-back command, and the color tables.
// No dependencies.
`timescale 1ns / 1ps

package plrf_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] top_row;
        logic [6:0] left_column;
        logic [7:0] rect_width;
        logic [7:0] rect_height;
        logic [1:0] gray_color;
    } t_in_item;

    typedef struct packed {
        logic       is_read_reply;
        logic [7:0] high_plane_byte;
        logic [7:0] low_plane_byte;
    } t_out_item;

    localparam logic ACTION_FILL = 1'b0;
    localparam logic ACTION_READ = 1'b1;

    typedef enum logic [1:0] {
        KIND_FILL,
        KIND_READ,
        KIND_EMPTY_FILL,
        KIND_ZERO_READ
    } t_cmd_kind;

    // Pages and columns keep the widths that the input fields allow; the front
    // guarantees they are inside the frame for the kinds that touch the store.
    typedef struct packed {
        t_cmd_kind  kind;
        logic [4:0] first_page;
        logic [4:0] last_page;
        logic [7:0] first_col;
        logic [7:0] last_col;
        logic [7:0] first_mask;
        logic [7:0] last_mask;
        logic [7:0] hi_pat;
        logic [7:0] lo_pat;
    } t_cmd;

    localparam logic [7:0] HIGH_PLANE_OF [4] = '{8'h00, 8'h00, 8'hff, 8'hff};
    localparam logic [7:0] LOW_PLANE_OF  [4] = '{8'h00, 8'hff, 8'h00, 8'hff};
    localparam logic [7:0] FULL_MASK = 8'hff;

endpackage

/* hdl/plrf_front.sv */
// Front end of the rectangle fill block: input handshake and item classification.
// Clips the rectangle and builds the row masks; depends on plrf_pkg.
`timescale 1ns / 1ps

module plrf_front #(
    parameter int PAGE_COUNT   = 22,
    parameter int COLUMN_COUNT = 128
) (
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  plrf_pkg::t_in_item i_in_item,
    input  logic               i_queue_full,
    input  logic               i_clear_done,
    output logic               o_push,
    output plrf_pkg::t_cmd     o_cmd
);
    import plrf_pkg::*;

    localparam logic [8:0] Rows = 9'(PAGE_COUNT * 8);
    localparam logic [8:0] Cols = 9'(COLUMN_COUNT);

    logic [8:0] bottom;
    logic [8:0] bottom_clip;
    logic [8:0] right;
    logic [8:0] right_clip;
    logic [7:0] last_row;
    logic [7:0] last_col;
    logic       fill_empty;
    logic       read_inside;

    assign o_in_ready = !i_queue_full && i_clear_done;
    assign o_push     = i_in_valid && o_in_ready;

    always_comb begin
        bottom      = {1'b0, i_in_item.top_row} + {1'b0, i_in_item.rect_height};
        bottom_clip = (bottom > Rows) ? Rows : bottom;
        right       = {2'b00, i_in_item.left_column} + {1'b0, i_in_item.rect_width};
        right_clip  = (right > Cols) ? Cols : right;
        last_row    = 8'(bottom_clip - 9'd1);
        last_col    = 8'(right_clip - 9'd1);

        // A rectangle that lies wholly outside the frame changes nothing.
        fill_empty = (i_in_item.rect_height == 8'd0) || (i_in_item.rect_width == 8'd0)
                  || ({2'b00, i_in_item.left_column} >= Cols)
                  || ({1'b0, i_in_item.top_row} >= Rows);
        read_inside = ({4'b0000, i_in_item.top_row[7:3]} < Rows[8:0] >> 3)
                   && ({2'b00, i_in_item.left_column} < Cols);

        o_cmd.first_page = i_in_item.top_row[7:3];
        o_cmd.last_page  = last_row[7:3];
        o_cmd.first_col  = {1'b0, i_in_item.left_column};
        o_cmd.last_col   = last_col;
        o_cmd.first_mask = FULL_MASK << i_in_item.top_row[2:0];
        o_cmd.last_mask  = FULL_MASK >> (3'd7 - last_row[2:0]);
        o_cmd.hi_pat     = HIGH_PLANE_OF[i_in_item.gray_color];
        o_cmd.lo_pat     = LOW_PLANE_OF[i_in_item.gray_color];

        if (i_in_item.action == ACTION_READ) begin
            o_cmd.kind = read_inside ? KIND_READ : KIND_ZERO_READ;
        end else begin
            o_cmd.kind = fill_empty ? KIND_EMPTY_FILL : KIND_FILL;
        end
    end

endmodule

/* hdl/plrf_queue.sv */
// Two-entry command queue between the front end and the store sequencer.
// Lets the front keep accepting while the back works; depends on plrf_pkg.
`timescale 1ns / 1ps

module plrf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  plrf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output plrf_pkg::t_cmd o_cmd
);
    import plrf_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = do_push ? !r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? !r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hdl/plrf_back.sv */
// Back end of the rectangle fill block: the frame store and its sequencer.
// Clears the store after reset, runs fills as one read-modify-write per cycle,
// serves column reads and holds the result register; depends on plrf_pkg.
`timescale 1ns / 1ps

module plrf_back #(
    parameter int PAGE_COUNT   = 22,
    parameter int COLUMN_COUNT = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  plrf_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_clear_done,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output plrf_pkg::t_out_item o_out_item
);
    import plrf_pkg::*;

    localparam int Depth = PAGE_COUNT * COLUMN_COUNT;
    localparam int AB    = $clog2(Depth);
    localparam int PB    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CB    = $clog2(COLUMN_COUNT);
    localparam logic [AB-1:0] ColsA = AB'(COLUMN_COUNT);
    localparam logic [AB-1:0] LastAddr = AB'(Depth - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_DRAIN,
        ST_READ
    } t_state;

    t_state        r_state, n_state;
    logic [AB-1:0] r_clr_addr, n_clr_addr;
    logic [PB-1:0] r_page, n_page;
    logic [CB-1:0] r_col, n_col;
    t_cmd          r_cmd, n_cmd;
    logic          r_wr_valid, n_wr_valid;
    logic [AB-1:0] r_wr_addr, n_wr_addr;
    logic [7:0]    r_wr_mask, n_wr_mask;
    logic          r_out_valid, n_out_valid;
    t_out_item     r_out_item, n_out_item;

    logic [15:0]   mem [Depth];
    logic [15:0]   r_mem_q;
    logic          mem_re;
    logic [AB-1:0] mem_raddr;
    logic          mem_we;
    logic [AB-1:0] mem_waddr;
    logic [15:0]   mem_wdata;

    logic [AB-1:0] fill_addr;
    logic [7:0]    page_mask;
    logic          is_first_page;
    logic          is_last_page;

    function automatic logic [AB-1:0] word_addr(logic [PB-1:0] page, logic [CB-1:0] col);
        return AB'(AB'(page) * ColsA) + AB'(col);
    endfunction

    assign o_clear_done = (r_state != ST_CLEAR);
    assign o_out_valid  = r_out_valid;
    assign o_out_item   = r_out_item;

    always_comb begin
        fill_addr     = word_addr(r_page, r_col);
        is_first_page = (r_page == r_cmd.first_page[PB-1:0]);
        is_last_page  = (r_page == r_cmd.last_page[PB-1:0]);
        page_mask     = (is_first_page ? r_cmd.first_mask : FULL_MASK)
                      & (is_last_page ? r_cmd.last_mask : FULL_MASK);

        // The write lands in the cycle after its read, when the old word is in r_mem_q.
        mem_we    = (r_state == ST_CLEAR) || r_wr_valid;
        mem_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_wr_addr;
        if (r_state == ST_CLEAR) begin
            mem_wdata = 16'h0000;
        end else begin
            mem_wdata = (r_mem_q & ~{r_wr_mask, r_wr_mask})
                      | {r_cmd.hi_pat & r_wr_mask, r_cmd.lo_pat & r_wr_mask};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_page      = r_page;
        n_col       = r_col;
        n_cmd       = r_cmd;
        n_wr_valid  = 1'b0;
        n_wr_addr   = r_wr_addr;
        n_wr_mask   = r_wr_mask;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        o_cmd_pop   = 1'b0;
        mem_re      = 1'b0;
        mem_raddr   = fill_addr;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AB'(1);
                if (r_clr_addr == LastAddr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // The result register is empty whenever a command is started,
                // so each command can finish without waiting on the output.
                if (i_cmd_valid && !r_out_valid) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_page    = i_cmd.first_page[PB-1:0];
                    n_col     = i_cmd.first_col[CB-1:0];
                    unique case (i_cmd.kind)
                        KIND_FILL: begin
                            n_state = ST_FILL;
                        end
                        KIND_READ: begin
                            mem_re    = 1'b1;
                            mem_raddr = word_addr(i_cmd.first_page[PB-1:0],
                                                  i_cmd.first_col[CB-1:0]);
                            n_state   = ST_READ;
                        end
                        KIND_EMPTY_FILL: begin
                            n_out_valid = 1'b1;
                            n_out_item  = '{is_read_reply: 1'b0, default: '0};
                        end
                        KIND_ZERO_READ: begin
                            n_out_valid = 1'b1;
                            n_out_item  = '{is_read_reply: 1'b1, default: '0};
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                mem_re     = 1'b1;
                n_wr_valid = 1'b1;
                n_wr_addr  = fill_addr;
                n_wr_mask  = page_mask;
                if (r_col == r_cmd.last_col[CB-1:0]) begin
                    n_col = r_cmd.first_col[CB-1:0];
                    if (is_last_page) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_page = r_page + PB'(1);
                    end
                end else begin
                    n_col = r_col + CB'(1);
                end
            end
            ST_DRAIN: begin
                n_out_valid = 1'b1;
                n_out_item  = '{is_read_reply: 1'b0, default: '0};
                n_state     = ST_IDLE;
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_out_item  = '{is_read_reply: 1'b1,
                                high_plane_byte: r_mem_q[15:8],
                                low_plane_byte: r_mem_q[7:0]};
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_wr_valid  <= n_wr_valid;
            r_out_valid <= n_out_valid;
        end
        r_page     <= n_page;
        r_col      <= n_col;
        r_cmd      <= n_cmd;
        r_wr_addr  <= n_wr_addr;
        r_wr_mask  <= n_wr_mask;
        r_out_item <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_raddr];
        end
    end

endmodule

/* hdl/paged_lcd_rect_fill.sv */
// Top level of the paged LCD rectangle fill block.
// Ties the front end, the command queue and the store sequencer together;
// depends on plrf_pkg, plrf_front, plrf_queue and plrf_back.
`timescale 1ns / 1ps

// A 2-bit grayscale frame of PAGE_COUNT pages of 8 rows by COLUMN_COUNT columns,
// stored as one 16-bit word (high plane byte, low plane byte) per page column in
// a single memory. Every item, fill or read, returns exactly one result. A fill
// visits each touched column of each touched page in turn, one read-modify-write
// per cycle, the bound that the store's single write port allows. The front end
// queues up to two items ahead of the one in progress. After reset the store is
// cleared one word per cycle, during which no item is taken.
module paged_lcd_rect_fill #(
    parameter int PAGE_COUNT   = 22,
    parameter int COLUMN_COUNT = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  plrf_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output plrf_pkg::t_out_item o_out_item
);
    import plrf_pkg::*;

    logic queue_full;
    logic queue_valid;
    logic push;
    logic pop;
    logic clear_done;
    t_cmd front_cmd;
    t_cmd head_cmd;

    plrf_front #(
        .PAGE_COUNT  (PAGE_COUNT),
        .COLUMN_COUNT(COLUMN_COUNT)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_queue_full(queue_full),
        .i_clear_done(clear_done),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    plrf_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (front_cmd),
        .o_full (queue_full),
        .i_pop  (pop),
        .o_valid(queue_valid),
        .o_cmd  (head_cmd)
    );

    plrf_back #(
        .PAGE_COUNT  (PAGE_COUNT),
        .COLUMN_COUNT(COLUMN_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (pop),
        .o_clear_done(clear_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

/* sim/tb_paged_lcd_rect_fill.sv */
// Self-checking testbench for paged_lcd_rect_fill: directed and random fill and read
// transfers, checked against a mirror of the frame kept in a small scoreboard class.
// Depends on plrf_pkg and the paged_lcd_rect_fill RTL.
`timescale 1ns / 1ps

module tb_paged_lcd_rect_fill;
    import plrf_pkg::*;

    localparam int PAGES        = 22;
    localparam int COLUMNS      = 128;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int MAX_PRINTED  = 100;

    class frame_scoreboard;
        logic [15:0] frame_words [PAGES*COLUMNS];
        t_out_item   expected_replies [$];
        int          error_count;

        function new();
            foreach (frame_words[i]) frame_words[i] = '0;
            error_count = 0;
        endfunction

        // Clips the rectangle to the frame and rewrites the covered rows of both planes.
        function void paint_rect(t_in_item it);
            int bottom, right, base, lo, hi, page, col, r;
            logic [7:0]  mask;
            logic [15:0] color_word;
            if (it.rect_height == 0 || it.rect_width == 0) return;
            bottom = int'(it.top_row) + int'(it.rect_height);
            right  = int'(it.left_column) + int'(it.rect_width);
            if (right > COLUMNS) right = COLUMNS;
            color_word = {{8{it.gray_color[1]}}, {8{it.gray_color[0]}}};
            for (page = 0; page < PAGES; page++) begin
                base = page * 8;
                lo = (int'(it.top_row) > base) ? int'(it.top_row) : base;
                hi = (bottom < base + 8) ? bottom : base + 8;
                if (lo < hi) begin
                    mask = '0;
                    for (r = lo - base; r < hi - base; r++) mask[r] = 1'b1;
                    for (col = int'(it.left_column); col < right; col++) begin
                        frame_words[page*COLUMNS + col] =
                            (frame_words[page*COLUMNS + col] & ~{mask, mask})
                            | (color_word & {mask, mask});
                    end
                end
            end
        endfunction

        function void note_accepted_item(t_in_item it);
            t_out_item reply;
            int page;
            reply = '0;
            if (it.action == ACTION_READ) begin
                reply.is_read_reply = 1'b1;
                page = int'(it.top_row) >> 3;
                if (page < PAGES && int'(it.left_column) < COLUMNS)
                    {reply.high_plane_byte, reply.low_plane_byte} =
                        frame_words[page*COLUMNS + int'(it.left_column)];
            end else begin
                paint_rect(it);
            end
            expected_replies.push_back(reply);
        endfunction

        task report_mismatch(string what);
            error_count++;
            if (error_count <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_reply(t_out_item got);
            t_out_item want;
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected reply %0h with nothing outstanding", got));
                return;
            end
            want = expected_replies.pop_front();
            if (got.is_read_reply !== want.is_read_reply)
                report_mismatch($sformatf("is_read_reply got %0b want %0b",
                                          got.is_read_reply, want.is_read_reply));
            if (got.high_plane_byte !== want.high_plane_byte)
                report_mismatch($sformatf("high_plane_byte got %0h want %0h",
                                          got.high_plane_byte, want.high_plane_byte));
            if (got.low_plane_byte !== want.low_plane_byte)
                report_mismatch($sformatf("low_plane_byte got %0h want %0h",
                                          got.low_plane_byte, want.low_plane_byte));
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    frame_scoreboard board;
    int        cycle_count = 0;
    bit        calm_stretch = 1'b0;
    bit        long_hold_request = 1'b0;
    t_in_item  last_fill = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    paged_lcd_rect_fill #(
        .PAGE_COUNT  (PAGES),
        .COLUMN_COUNT(COLUMNS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    // Both sides change only by nonblocking assignment, so values seen here are
    // the ones the block sampled at this edge.
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n) begin
            if (i_in_valid === 1'b1 && o_in_ready === 1'b1)
                board.note_accepted_item(i_in_item);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1)
                board.check_reply(o_out_item);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic t_in_item make_item(logic action, logic [7:0] top, logic [6:0] left,
                                           logic [7:0] width, logic [7:0] height,
                                           logic [1:0] color);
        t_in_item it;
        it.action      = action;
        it.top_row     = top;
        it.left_column = left;
        it.rect_width  = width;
        it.rect_height = height;
        it.gray_color  = color;
        return it;
    endfunction

    // Mostly small rectangles keep the run short; a few wide ones cover the
    // upper bits of every field and the clipping paths.
    function automatic t_in_item random_item();
        t_in_item it;
        int pick;
        pick = $urandom_range(0, 99);
        it.gray_color  = 2'($urandom_range(0, 3));
        it.rect_width  = 8'($urandom_range(0, 255));
        it.rect_height = 8'($urandom_range(0, 255));
        if (pick < 40) begin
            it.action = ACTION_READ;
            if (pick < 20) begin
                it.top_row     = last_fill.top_row + 8'($urandom_range(0, 15));
                it.left_column = last_fill.left_column + 7'($urandom_range(0, 15));
            end else begin
                it.top_row     = (pick < 37) ? 8'($urandom_range(0, 175))
                                             : 8'($urandom_range(0, 255));
                it.left_column = 7'($urandom_range(0, 127));
            end
        end else begin
            it.action      = ACTION_FILL;
            it.left_column = 7'($urandom_range(0, 127));
            if (pick < 88) begin
                it.top_row     = 8'($urandom_range(0, 175));
                it.rect_width  = 8'($urandom_range(0, 20));
                it.rect_height = 8'($urandom_range(0, 20));
            end else if (pick < 95) begin
                it.top_row     = 8'($urandom_range(0, 175));
                it.rect_width  = 8'($urandom_range(0, 128));
                it.rect_height = 8'($urandom_range(0, 24));
            end else begin
                it.top_row = 8'($urandom_range(0, 255));
            end
            last_fill = it;
        end
        return it;
    endfunction

    // Valid is lowered only when a gap is drawn, so back-to-back transfers keep it high.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = calm_stretch ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic drain_replies();
        int idle;
        bit holding;
        forever begin
            holding = long_hold_request;
            if (holding) idle = HOLD_CYCLES;
            else idle = calm_stretch ? 0 : $urandom_range(0, 4);
            if (idle > 0) begin
                i_out_ready <= 1'b0;
                repeat (idle) @(posedge i_clk);
                if (holding) long_hold_request = 1'b0;
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        send_item(make_item(ACTION_READ, 0, 0, 0, 0, 0));
        send_item(make_item(ACTION_FILL, 0, 0, 128, 176, 3));
        send_item(make_item(ACTION_READ, 0, 0, 0, 0, 0));
        send_item(make_item(ACTION_READ, 175, 127, 0, 0, 0));
        // Zero height and zero width must leave the frame alone.
        send_item(make_item(ACTION_FILL, 0, 0, 128, 0, 0));
        send_item(make_item(ACTION_READ, 0, 0, 0, 0, 0));
        send_item(make_item(ACTION_FILL, 0, 0, 0, 176, 0));
        send_item(make_item(ACTION_READ, 100, 64, 0, 0, 0));
        // Rows 3 to 12 span a partial top page and a partial bottom page.
        send_item(make_item(ACTION_FILL, 3, 5, 4, 10, 1));
        send_item(make_item(ACTION_READ, 0, 5, 0, 0, 0));
        send_item(make_item(ACTION_READ, 8, 8, 0, 0, 0));
        send_item(make_item(ACTION_READ, 8, 9, 0, 0, 0));
        send_item(make_item(ACTION_FILL, 20, 120, 128, 5, 2));
        send_item(make_item(ACTION_READ, 20, 127, 0, 0, 0));
        send_item(make_item(ACTION_FILL, 170, 100, 3, 176, 0));
        send_item(make_item(ACTION_READ, 175, 101, 0, 0, 0));
        // Position and size fields at their largest: the rectangle lies wholly below the frame.
        send_item(make_item(ACTION_FILL, 255, 127, 255, 255, 1));
        send_item(make_item(ACTION_READ, 255, 127, 255, 255, 3));
        send_item(make_item(ACTION_READ, 176, 0, 0, 0, 0));
        send_item(make_item(ACTION_FILL, 7, 127, 1, 1, 2));
        send_item(make_item(ACTION_READ, 7, 127, 0, 0, 0));
        send_item(make_item(ACTION_FILL, 0, 0, 255, 255, 1));
        send_item(make_item(ACTION_READ, 90, 60, 0, 0, 0));
        send_item(make_item(ACTION_FILL, 8, 0, 128, 8, 2));
        send_item(make_item(ACTION_READ, 15, 0, 0, 0, 0));
    endtask

    initial begin
        int n;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_replies();
        join_none
        run_directed();
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm_stretch = ((n / 250) % 3) == 1;
            // The receiver stalls for a long stretch so the input side backs up.
            if (n == 400 || n == 1300) long_hold_request = 1'b1;
            send_item(random_item());
        end
        i_in_valid <= 1'b0;
        while (board.expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
